// ===== hw/rtl/blup2_pkg.sv =====
package blup2_pkg;

  // payload widths fixed by the pixel format and the output coordinates
  localparam int PIX_W = 8;
  localparam int POS_W = 11;
  localparam int CFG_W = 11;
  localparam int REG_IDX_W = 1;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // signed intermediate wide enough for extrapolated values (-1020..1275)
  localparam int VAL_W = 12;
  typedef logic signed [VAL_W-1:0] val_t;

  // one source pixel's worth of work for the back end
  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] curl;
    logic [PIX_W-1:0] prev;
    logic [PIX_W-1:0] prevl;
    logic [POS_W-1:0] row2;
    logic [POS_W-1:0] col2;
    logic             has_up;
    logic             lastcol;
    logic             lastrow;
  } job_t;

  // output row within one job
  typedef enum logic [2:0] {
    ROW_UP  = 3'b001,
    ROW_MID = 3'b010,
    ROW_LOW = 3'b100
  } row_sel_e;

  // column slot within one output row
  localparam logic [1:0] SLOT_LEFT   = 2'd0;
  localparam logic [1:0] SLOT_PAIR   = 2'd1;
  localparam logic [1:0] SLOT_EDGE_A = 2'd2;
  localparam logic [1:0] SLOT_EDGE_B = 2'd3;

  function automatic val_t ext8(input logic [PIX_W-1:0] x);
    ext8 = val_t'({{(VAL_W-PIX_W){1'b0}}, x});
  endfunction

  // halve with truncation toward zero
  function automatic val_t half2(input val_t s);
    val_t t;
    t = s + val_t'({{(VAL_W-1){1'b0}}, s[VAL_W-1]});
    half2 = t >>> 1;
  endfunction

  function automatic logic [PIX_W-1:0] clamp8(input val_t s);
    if (s < 0) begin
      clamp8 = '0;
    end else if (s > val_t'(255)) begin
      clamp8 = '1;
    end else begin
      clamp8 = s[PIX_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/blup2_if.sv =====
interface blup2_in_if import blup2_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface blup2_out_if import blup2_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             frame_last;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input pixel_out, input out_row, input out_col,
                input frame_last, output ready);
endinterface

// ===== hw/rtl/blup2_fifo.sv =====
module blup2_fifo import blup2_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o
);

  job_t               entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]    count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/blup2_front.sv =====
module blup2_front import blup2_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] width_i,
  input  logic [CFG_W-1:0] height_i,
  blup2_in_if.sink         in_i,
  output logic             push_o,
  output job_t             push_data_o,
  input  logic             full_i
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int HH = (HW + 1 > CFG_W) ? HW + 1 : CFG_W;

  logic [PIX_W-1:0] line_buf_q [MAX_WIDTH];
  logic [PIX_W-1:0] prev_q;
  logic [CW-1:0]    col_q, col_d;
  logic [HW-1:0]    row_q, row_d;
  logic [WW-1:0]    w_raw, w_eff;
  logic [HH-1:0]    h_raw, h_eff;
  logic             lastcol, lastrow, in_fire;
  logic [CW-1:0]    c_eff;
  logic [HW-1:0]    r_eff;

  logic             s1_vld_q, s1_go;
  logic [PIX_W-1:0] s1_cur_q;
  logic [CW-1:0]    s1_c_q;
  logic [HW-1:0]    s1_r_q;
  logic             s1_lastcol_q, s1_lastrow_q;
  logic [PIX_W-1:0] curl_q, prevl_q;

  // effective frame size, clamped to 2..max
  always_comb begin
    w_raw = WW'(width_i);
    h_raw = HH'(height_i);
    if (w_raw < WW'(2)) begin
      w_eff = WW'(2);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < HH'(2)) begin
      h_eff = HH'(2);
    end else if (h_raw > HH'(MAX_HEIGHT)) begin
      h_eff = HH'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // position classification
  always_comb begin
    lastcol = (WW'(col_q) >= w_eff - WW'(1));
    lastrow = (HH'(row_q) >= h_eff - HH'(1));
    c_eff   = lastcol ? CW'(w_eff - WW'(1)) : col_q;
    r_eff   = lastrow ? HW'(h_eff - HH'(1)) : row_q;
    if (lastcol) begin
      col_d = '0;
      row_d = lastrow ? '0 : r_eff + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
      row_d = row_q;
    end
  end

  assign s1_go     = s1_vld_q && !(full_i && (s1_c_q != '0));
  assign in_i.ready = !s1_vld_q || s1_go;
  assign in_fire   = in_i.valid && in_i.ready;

  // source position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line buffer of the previous source row, read before write
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prev_q             <= line_buf_q[col_q];
      line_buf_q[col_q]  <= in_i.pixel_in;
    end
  end

  // second stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cur_q     <= in_i.pixel_in;
      s1_c_q       <= c_eff;
      s1_r_q       <= r_eff;
      s1_lastcol_q <= lastcol;
      s1_lastrow_q <= lastrow;
    end
  end

  // second stage valid and left neighbors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      curl_q   <= '0;
      prevl_q  <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_go) begin
        curl_q  <= s1_lastcol_q ? '0 : s1_cur_q;
        prevl_q <= s1_lastcol_q ? '0 : prev_q;
      end
    end
  end

  // job to the back end; column zero releases nothing
  assign push_o = s1_go && (s1_c_q != '0);
  always_comb begin
    push_data_o.cur     = s1_cur_q;
    push_data_o.curl    = curl_q;
    push_data_o.prev    = prev_q;
    push_data_o.prevl   = prevl_q;
    push_data_o.row2    = POS_W'({s1_r_q, 1'b0});
    push_data_o.col2    = POS_W'({s1_c_q, 1'b0});
    push_data_o.has_up  = (s1_r_q != '0);
    push_data_o.lastcol = s1_lastcol_q;
    push_data_o.lastrow = s1_lastrow_q;
  end

endmodule

// ===== hw/rtl/blup2_back.sv =====
module blup2_back import blup2_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  blup2_out_if.source out_o
);

  job_t       job_q;
  logic       job_vld_q;
  row_sel_e   row_q;
  logic [1:0] slot_q;
  logic       out_vld_q;
  logic       step, last_slot, last_row, done, load;
  val_t       vl, vr, v;
  logic [POS_W-1:0] row_pos, col_pos;

  // sequencing of the current job
  assign step      = job_vld_q && (!out_vld_q || out_o.ready);
  assign last_slot = job_q.lastcol ? (slot_q == SLOT_EDGE_B) : (slot_q == SLOT_PAIR);
  assign last_row  = (row_q == ROW_LOW) || ((row_q == ROW_MID) && !job_q.lastrow);
  assign done      = step && last_slot && last_row;
  assign load      = (!job_vld_q || done) && !empty_i;
  assign pop_o     = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      row_q     <= ROW_MID;
      slot_q    <= SLOT_LEFT;
    end else if (load) begin
      job_vld_q <= 1'b1;
      row_q     <= head_i.has_up ? ROW_UP : ROW_MID;
      slot_q    <= SLOT_LEFT;
    end else if (done) begin
      job_vld_q <= 1'b0;
    end else if (step) begin
      if (last_slot) begin
        slot_q <= SLOT_LEFT;
        row_q  <= (row_q == ROW_UP) ? ROW_MID : ROW_LOW;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= head_i;
    end
  end

  // column-wise values of the selected output row
  always_comb begin
    case (row_q)
      ROW_UP: begin
        vl      = half2(ext8(job_q.prevl) + ext8(job_q.curl));
        vr      = half2(ext8(job_q.prev) + ext8(job_q.cur));
        row_pos = job_q.row2 - POS_W'(1);
      end
      ROW_LOW: begin
        vl      = (ext8(job_q.curl) <<< 1) - ext8(job_q.prevl);
        vr      = (ext8(job_q.cur) <<< 1) - ext8(job_q.prev);
        row_pos = job_q.row2 + POS_W'(1);
      end
      default: begin
        vl      = ext8(job_q.curl);
        vr      = ext8(job_q.cur);
        row_pos = job_q.row2;
      end
    endcase
  end

  // horizontal interpolation or extrapolation
  always_comb begin
    case (slot_q)
      SLOT_LEFT:   v = vl;
      SLOT_PAIR:   v = half2(vl + vr);
      SLOT_EDGE_A: v = vr;
      default:     v = (vr <<< 1) - vl;
    endcase
    col_pos = job_q.col2 + POS_W'(slot_q) - POS_W'(2);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_o.pixel_out  <= clamp8(v);
      out_o.out_row    <= row_pos;
      out_o.out_col    <= col_pos;
      out_o.frame_last <= (row_q == ROW_LOW) && (slot_q == SLOT_EDGE_B);
    end
  end

  assign out_o.valid = out_vld_q;

endmodule

// ===== hw/rtl/bilinear_upscale_by_two.sv =====
// channel  | dir | payload                                  | transaction
// in_i     | in  | pixel_in[7:0]                            | valid && ready
// out_o    | out | pixel_out[7:0] out_row[10:0] out_col[10:0] frame_last | valid && ready
// cfg      | in  | cfg_idx_i, cfg_data_i[10:0]              | cfg_we_i
//
// one source pixel enters per cycle while the job queue has room; it yields 0 to 12
// output pixels, 4 on average, and the output register sends one pixel per cycle while
// out_o is ready, so over a frame the output side bounds the source rate.
// the first output of a job follows its input transaction through the line buffer
// read at the transaction, then the job queue, sequencer load and output register.
// reset clears counters and handshake state; the line buffer is not cleared, and an entry
// is written in a frame before its value is used. either side may stall at any time.
module bilinear_upscale_by_two import blup2_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  blup2_in_if.sink             in_i,
  blup2_out_if.source          out_o
);

  logic [CFG_W-1:0] width_q, height_q;
  logic             push, pop, full, empty;
  job_t             push_data, head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(2);
      height_q <= CFG_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: line buffer, counters, job building
  blup2_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .height_i    (height_q),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // job queue
  blup2_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  // back: per pixel sequencer and output register
  blup2_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== hw/rtl/blup2_checker.sv =====
module blup2_checker import blup2_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] pixel_out_i,
  input logic [POS_W-1:0] out_row_i,
  input logic [POS_W-1:0] out_col_i,
  input logic             frame_last_i
);

  logic seen_q;

  // remember that some input transaction happened
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (in_valid_i && in_ready_i) begin
      seen_q <= 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_out_i)
      && $stable(out_row_i) && $stable(out_col_i) && $stable(frame_last_i))
    else $error("stalled output changed");

  // frame end sits at an odd row and odd column
  a_frame_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_last_i |-> out_row_i[0] && out_col_i[0])
    else $error("frame_last at even position");

  // no result before any source pixel
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_q)
    else $error("output without input");

endmodule

bind bilinear_upscale_by_two blup2_checker u_blup2_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .pixel_out_i  (out_o.pixel_out),
  .out_row_i    (out_o.out_row),
  .out_col_i    (out_o.out_col),
  .frame_last_i (out_o.frame_last)
);
